// File: hw/rtl/ja3d_pkg.sv
// ----------------------------------------------------------------------------
// ja3d_pkg: shared constants and tables for the joint angle block
// Holds the default coordinate width and the per-degree cosine threshold
// table used by the angle search steps.
// ----------------------------------------------------------------------------
package ja3d_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int ANGLE_W        = 8;
  localparam int ANGLE_MAX      = 180;
  localparam int THR_SQ_W       = 34;
  // Slice width of the split wide multiplies
  localparam int MUL_W          = 24;
  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned DEG_RAD_Q30 = 64'd18740330;

  // Threshold entry: {cosine is non-negative, squared compare constant}
  typedef logic [THR_SQ_W:0] thr_ent_t;
  typedef thr_ent_t thr_tab_t [0:(1 << ANGLE_W) - 1];

  // Taylor term divisor (2n-1)*2n, written out per term
  function automatic longint unsigned term_div(input longint unsigned t, input int n);
    longint unsigned r;
    r = t;
    case (n)
      1:  r = t / 2;
      2:  r = t / 12;
      3:  r = t / 30;
      4:  r = t / 56;
      5:  r = t / 90;
      6:  r = t / 132;
      7:  r = t / 182;
      8:  r = t / 240;
      9:  r = t / 306;
      10: r = t / 380;
      11: r = t / 462;
      12: r = t / 552;
      default: r = t;
    endcase
    return r;
  endfunction

  // Cosine of d degrees rounded to Q1.16, d in 0..180
  function automatic int cos_deg_q16(input int d_in);
    int              d;
    bit              neg;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          sum;
    int              q;
    d   = d_in;
    neg = 1'b0;
    if (d > 90) begin
      d   = 180 - d;
      neg = 1'b1;
    end
    x   = longint'(d) * DEG_RAD_Q30;
    x2  = (x * x + (Q30_ONE >> 1)) >> 30;
    t   = Q30_ONE;
    sum = longint'(Q30_ONE);
    for (int n = 1; n <= 12; n++) begin
      t = term_div((t * x2 + (Q30_ONE >> 1)) >> 30, n);
      if (n % 2 == 1) sum = sum - longint'(t);
      else            sum = sum + longint'(t);
    end
    if (sum < 0) sum = 0;
    q = int'((longint'(sum) + 8192) >>> 14);
    return neg ? -q : q;
  endfunction

  // Build the compare table: for T >= 0 the constant is (T+1)^2, else T^2
  function automatic thr_tab_t build_thr();
    thr_tab_t        tab;
    int              tv;
    longint unsigned c;
    for (int i = 0; i < (1 << ANGLE_W); i++) tab[i] = '0;
    for (int i = 0; i <= ANGLE_MAX; i++) begin
      tv = cos_deg_q16(i);
      c  = (tv >= 0) ? longint'(tv + 1) : longint'(-tv);
      tab[i] = {(tv >= 0), THR_SQ_W'(c * c)};
    end
    return tab;
  endfunction

  localparam thr_tab_t THR_TAB = build_thr();

endpackage

// File: hw/rtl/ja3d_step.sv
// ----------------------------------------------------------------------------
// ja3d_step: one bit of the angle search
// Tries setting one angle bit and keeps it when the cosine still lies at or
// below the threshold of the candidate degree. The first stage forms the
// threshold product in MUL_W-bit slices, the second adds and compares.
// ----------------------------------------------------------------------------
module ja3d_step
  import ja3d_pkg::*;
#(
  parameter int BIT_POS = 0,
  parameter int SUM_W   = 38
) (
  input  logic               clk,
  input  logic               en_i,
  input  logic [ANGLE_W-1:0] cur_i,
  input  logic [2*SUM_W-1:0] pq_i,
  input  logic [2*SUM_W-1:0] dd_i,
  input  logic               neg_i,
  output logic [ANGLE_W-1:0] nxt_o
);

  localparam int PQ_W  = 2 * SUM_W;
  localparam int NQ    = (PQ_W + MUL_W - 1) / MUL_W;
  localparam int QX_W  = NQ * MUL_W;
  localparam int PP_W  = THR_SQ_W + MUL_W;
  localparam int CMP_W = 2 * SUM_W + THR_SQ_W;

  logic [ANGLE_W-1:0] cand_nxt;
  logic [ANGLE_W-1:0] cand_r;
  logic               pos_nxt;
  logic               pos_r;
  thr_ent_t           ent;
  logic [QX_W-1:0]    pq_ext;
  logic [PP_W-1:0]    pp_nxt [NQ];
  logic [PP_W-1:0]    pp_r [NQ];
  logic [ANGLE_W-1:0] keep;
  logic [CMP_W-1:0]   lhs;
  logic [CMP_W-1:0]   rhs;
  logic               ok;

  // Look up the candidate threshold and multiply it by slices of |AB|^2*|BC|^2
  always_comb begin
    cand_nxt = cur_i | ANGLE_W'(1 << BIT_POS);
    ent      = THR_TAB[cand_nxt];
    pos_nxt  = ent[THR_SQ_W];
    pq_ext   = QX_W'(pq_i);
    for (int j = 0; j < NQ; j++)
      pp_nxt[j] = PP_W'(ent[THR_SQ_W-1:0]) * PP_W'(pq_ext[j*MUL_W +: MUL_W]);
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      cand_r <= cand_nxt;
      pos_r  <= pos_nxt;
      for (int j = 0; j < NQ; j++) pp_r[j] <= pp_nxt[j];
    end
  end

  // Compare dot^2 * 2^32 against threshold^2 * |AB|^2 * |BC|^2
  always_comb begin
    keep = cand_r & ~ANGLE_W'(1 << BIT_POS);
    lhs  = {2'b00, dd_i, 32'h0};
    rhs  = '0;
    for (int j = 0; j < NQ; j++) rhs = rhs + (CMP_W'(pp_r[j]) << (MUL_W * j));
    if (neg_i) ok = pos_r || (lhs >= rhs);
    else       ok = pos_r && (lhs < rhs);
    if (cand_r <= ANGLE_W'(ANGLE_MAX) && ok) nxt_o = cand_r;
    else                                     nxt_o = keep;
  end

endmodule

// File: hw/rtl/joint_angle_3d_top.sv
// ----------------------------------------------------------------------------
// joint_angle_3d_top: angle at a joint between vectors AB and BC
// Exact integer dot product and squared lengths, then a bitwise search for
// the largest whole degree whose Q1.16 cosine threshold holds.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | input     | a_x a_y a_z b_x b_y b_z c_x c_y c_z (COORD_BITS, signed)
//  out_    | output    | angle_deg (8), degenerate (1)
//
//  One transaction per cycle sustained while out_ready holds; 6 arithmetic stages
//  (differences, products, sums, dot magnitude, sliced wide products, their
//  sums) and 16 search stages, two per angle bit (sliced threshold product,
//  then add and compare). Each stage holds while its successor is full and
//  stalled, so bubbles close up and nothing is lost or repeated.
//  Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module joint_angle_3d_top
  import ja3d_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_a_x,
  input  logic signed [COORD_BITS-1:0] in_a_y,
  input  logic signed [COORD_BITS-1:0] in_a_z,
  input  logic signed [COORD_BITS-1:0] in_b_x,
  input  logic signed [COORD_BITS-1:0] in_b_y,
  input  logic signed [COORD_BITS-1:0] in_b_z,
  input  logic signed [COORD_BITS-1:0] in_c_x,
  input  logic signed [COORD_BITS-1:0] in_c_y,
  input  logic signed [COORD_BITS-1:0] in_c_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ANGLE_W-1:0]           out_angle_deg,
  output logic                         out_degenerate
);

  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 2;
  localparam int WW  = 2 * SW;
  localparam int NC  = (SW + MUL_W - 1) / MUL_W;
  localparam int XW  = NC * MUL_W;
  localparam int NA  = 6;
  localparam int NS  = NA + 2 * ANGLE_W;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  logic signed [DW-1:0] du [3];
  logic signed [DW-1:0] dv [3];

  logic [DW-1:0] mu_r [3];
  logic [DW-1:0] mv_r [3];
  logic          su_r [3];
  logic          sv_r [3];

  logic [PW-1:0] puu_r [3];
  logic [PW-1:0] pvv_r [3];
  logic [PW-1:0] puv_r [3];
  logic          xneg_r [3];

  logic [SW-1:0] p_r, q_r, pos_r, negs_r;
  logic [SW-1:0] p_nxt, q_nxt, pos_nxt, negs_nxt;

  logic [SW-1:0] p4_r, q4_r, dm_r;
  logic          dneg4_r, dgn4_r;

  logic [XW-1:0]        p4x, q4x, dmx;
  logic [2*MUL_W-1:0]   ppq_r [NC][NC];
  logic [2*MUL_W-1:0]   pdd_r [NC][NC];
  logic                 dneg5_r, dgn5_r;
  logic [WW-1:0]        pq_nxt, dd_nxt;

  logic [WW-1:0] pq_r [2*ANGLE_W+1];
  logic [WW-1:0] dd_r [2*ANGLE_W+1];
  logic          dneg_r [2*ANGLE_W+1];
  logic          dgn_r [2*ANGLE_W+1];
  logic [ANGLE_W-1:0] ang_r [ANGLE_W+1];
  logic [ANGLE_W-1:0] ang_nxt [ANGLE_W];

  // Stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
  end

  assign in_ready = en[0];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) if (en[i]) v_r[i] <= v_r[i-1];
    end
  end

  // Stage 1: coordinate differences as magnitude and sign
  always_comb begin
    du[0] = DW'(in_b_x) - DW'(in_a_x);
    du[1] = DW'(in_b_y) - DW'(in_a_y);
    du[2] = DW'(in_b_z) - DW'(in_a_z);
    dv[0] = DW'(in_c_x) - DW'(in_b_x);
    dv[1] = DW'(in_c_y) - DW'(in_b_y);
    dv[2] = DW'(in_c_z) - DW'(in_b_z);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        su_r[i] <= du[i][DW-1];
        sv_r[i] <= dv[i][DW-1];
        mu_r[i] <= du[i][DW-1] ? DW'(-du[i]) : DW'(du[i]);
        mv_r[i] <= dv[i][DW-1] ? DW'(-dv[i]) : DW'(dv[i]);
      end
    end
  end

  // Stage 2: per-axis squares and cross products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        puu_r[i]  <= PW'(mu_r[i]) * PW'(mu_r[i]);
        pvv_r[i]  <= PW'(mv_r[i]) * PW'(mv_r[i]);
        puv_r[i]  <= PW'(mu_r[i]) * PW'(mv_r[i]);
        xneg_r[i] <= su_r[i] ^ sv_r[i];
      end
    end
  end

  // Stage 3: squared lengths and split dot product sums
  always_comb begin
    p_nxt    = '0;
    q_nxt    = '0;
    pos_nxt  = '0;
    negs_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      p_nxt = p_nxt + SW'(puu_r[i]);
      q_nxt = q_nxt + SW'(pvv_r[i]);
      if (xneg_r[i]) negs_nxt = negs_nxt + SW'(puv_r[i]);
      else           pos_nxt  = pos_nxt + SW'(puv_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p_r    <= p_nxt;
      q_r    <= q_nxt;
      pos_r  <= pos_nxt;
      negs_r <= negs_nxt;
    end
  end

  // Stage 4: dot magnitude, dot sign, zero-length check
  always_ff @(posedge clk) begin
    if (en[3]) begin
      p4_r    <= p_r;
      q4_r    <= q_r;
      dneg4_r <= negs_r > pos_r;
      dm_r    <= (negs_r > pos_r) ? (negs_r - pos_r) : (pos_r - negs_r);
      dgn4_r  <= (p_r == '0) || (q_r == '0);
    end
  end

  // Stage 5: slice products of squared lengths and of the dot magnitude
  assign p4x = XW'(p4_r);
  assign q4x = XW'(q4_r);
  assign dmx = XW'(dm_r);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < NC; i++) begin
        for (int j = 0; j < NC; j++) begin
          ppq_r[i][j] <= (2*MUL_W)'(p4x[i*MUL_W +: MUL_W]) *
                         (2*MUL_W)'(q4x[j*MUL_W +: MUL_W]);
          pdd_r[i][j] <= (2*MUL_W)'(dmx[i*MUL_W +: MUL_W]) *
                         (2*MUL_W)'(dmx[j*MUL_W +: MUL_W]);
        end
      end
      dneg5_r <= dneg4_r;
      dgn5_r  <= dgn4_r;
    end
  end

  // Stage 6: add the slice products into |AB|^2*|BC|^2 and dot^2
  always_comb begin
    pq_nxt = '0;
    dd_nxt = '0;
    for (int i = 0; i < NC; i++) begin
      for (int j = 0; j < NC; j++) begin
        pq_nxt = pq_nxt + (WW'(ppq_r[i][j]) << (MUL_W * (i + j)));
        dd_nxt = dd_nxt + (WW'(pdd_r[i][j]) << (MUL_W * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      pq_r[0]   <= pq_nxt;
      dd_r[0]   <= dd_nxt;
      dneg_r[0] <= dneg5_r;
      dgn_r[0]  <= dgn5_r;
      ang_r[0]  <= '0;
    end
  end

  // Carry the operands and flags along the search stages
  for (genvar s = 0; s < 2 * ANGLE_W; s++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en[NA+s]) begin
        pq_r[s+1]   <= pq_r[s];
        dd_r[s+1]   <= dd_r[s];
        dneg_r[s+1] <= dneg_r[s];
        dgn_r[s+1]  <= dgn_r[s];
      end
    end
  end

  // Search stages: resolve one angle bit per stage pair, MSB first
  for (genvar k = 0; k < ANGLE_W; k++) begin : g_search
    ja3d_step #(
      .BIT_POS (ANGLE_W - 1 - k),
      .SUM_W   (SW)
    ) u_step (
      .clk   (clk),
      .en_i  (en[NA+2*k]),
      .cur_i (ang_r[k]),
      .pq_i  (pq_r[2*k]),
      .dd_i  (dd_r[2*k+1]),
      .neg_i (dneg_r[2*k+1]),
      .nxt_o (ang_nxt[k])
    );

    always_ff @(posedge clk) begin
      if (en[NA+2*k+1]) begin
        ang_r[k+1] <= ang_nxt[k];
      end
    end
  end

  // Drive the result; a zero-length vector reports angle 0
  assign out_valid      = v_r[NS-1];
  assign out_degenerate = dgn_r[2*ANGLE_W];
  assign out_angle_deg  = dgn_r[2*ANGLE_W] ? '0 : ang_r[ANGLE_W];

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_angle_deg == '0)
    else $error("degenerate result with nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angle_deg <= ANGLE_W'(ANGLE_MAX))
    else $error("angle beyond 180 degrees");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && v_r == '1))
    else $error("input stalled while pipeline has room");

endmodule
